>>> rtl/ospfe_pkg.sv
// Package for the OSPF DR/BDR election block: neighbor record, candidate,
// controller command/status types and the codes shared by the modules.
// No dependencies.
package ospfe_pkg;

   localparam int ID_W    = 32;
   localparam int PRIO_W  = 8;
   localparam int SLOT_W  = 4;
   localparam int ROLE_W  = 2;
   localparam int VER_W   = 2;
   localparam int CSR_A_W = 3;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_ELECT = 1'b1;

   localparam logic [ROLE_W-1:0] ROLE_WAITING  = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_DR_OTHER = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_BACKUP   = 2'd2;
   localparam logic [ROLE_W-1:0] ROLE_DR       = 2'd3;

   localparam logic [CSR_A_W-1:0] CSR_OWN_ROUTER_ID    = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_OWN_PRIORITY     = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_OWN_ADDRESS      = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_PROTOCOL_VERSION = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_POINT_TO_POINT   = 3'd4;

   localparam logic [VER_W-1:0] VERSION_BY_ADDRESS = 2'd2;

   typedef struct packed {
      logic              two_way;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   rid;
      logic [ID_W-1:0]   addr;
      logic [ID_W-1:0]   dr;
      logic [ID_W-1:0]   bdr;
   } nbr_type;

   localparam int NBR_W = $bits(nbr_type);

   typedef struct packed {
      logic              found;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   rid;
      logic [ID_W-1:0]   ident;
   } cand_type;

   typedef struct packed {
      logic write;
      logic start;
      logic step;
      logic resolve;
      logic role;
      logic load;
      logic changed;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;
      logic differ;
      logic p2p;
   } ctrl_status_type;

endpackage

>>> rtl/ospfe_if.sv
// Request and response channel interfaces of the OSPF DR/BDR election block.
// Depends on ospfe_pkg.
interface ospfe_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [ospfe_pkg::SLOT_W-1:0]        slot;
   logic                                entry_valid;
   logic                                two_way;
   logic [ospfe_pkg::PRIO_W-1:0]        priority_req;
   logic [ospfe_pkg::ID_W-1:0]          nbr_rid;
   logic [ospfe_pkg::ID_W-1:0]          address;
   logic [ospfe_pkg::ID_W-1:0]          declared_dr;
   logic [ospfe_pkg::ID_W-1:0]          declared_bdr;

   modport source (output valid, opcode, slot, entry_valid, two_way, priority_req,
                   nbr_rid, address, declared_dr, declared_bdr, input ready);
   modport sink (input valid, opcode, slot, entry_valid, two_way, priority_req,
                 nbr_rid, address, declared_dr, declared_bdr, output ready);
endinterface

interface ospfe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ospfe_pkg::ID_W-1:0]          dr_id;
   logic [ospfe_pkg::ID_W-1:0]          bdr_id;
   logic                                changed;
   logic [ospfe_pkg::ROLE_W-1:0]        role;

   modport source (output valid, dr_id, bdr_id, changed, role, input ready);
   modport sink (input valid, dr_id, bdr_id, changed, role, output ready);
endinterface

>>> rtl/ospf_dr_bdr_election.sv
// Top level of the OSPF DR/BDR election block: controller, datapath and
// channel interfaces. Depends on ospfe_pkg, ospfe_if, ospfe_ctrl, ospfe_dp.
//
// A write word fills one neighbor slot; a write to a slot at or beyond
// NEIGHBOR_SLOTS is dropped. An elect word gives one response word. With
// point-to-point set it answers with the stored DR, BDR and role. Otherwise
// the election walks the neighbor table RAM one slot per cycle after the
// local router is evaluated; when the DR/BDR pair changes, a second pass
// and the role update run. The next request word is taken once the election
// finishes, also while the previous response waits in the output register.
module ospf_dr_bdr_election #(
   parameter int NEIGHBOR_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ospfe_pkg::CSR_A_W-1:0] csr_index,
   input  logic [ospfe_pkg::ID_W-1:0]    csr_wdata,
   ospfe_req_if.sink                     req,
   ospfe_rsp_if.source                   rsp
);

   ospfe_pkg::ctrl_cmd_type    cmd;
   ospfe_pkg::ctrl_status_type status;
   ospfe_pkg::nbr_type         req_entry;

   assign req_entry.two_way = req.two_way;
   assign req_entry.prio    = req.priority_req;
   assign req_entry.rid     = req.nbr_rid;
   assign req_entry.addr    = req.address;
   assign req_entry.dr      = req.declared_dr;
   assign req_entry.bdr     = req.declared_bdr;

   ospfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd),
      .status     (status)
   );

   ospfe_dp #(
      .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_slot        (req.slot),
      .req_entry_valid (req.entry_valid),
      .req_entry       (req_entry),
      .cmd             (cmd),
      .status          (status),
      .rsp_dr_id       (rsp.dr_id),
      .rsp_bdr_id      (rsp.bdr_id),
      .rsp_changed     (rsp.changed),
      .rsp_role        (rsp.role)
   );

endmodule

>>> rtl/ospfe_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ospfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ospfe_ctrl.sv
// Controller of the OSPF DR/BDR election block: sequences slot writes,
// the election passes, role update and the response handshake.
// Depends on ospfe_pkg.
module ospfe_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_opcode,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ospfe_pkg::ctrl_cmd_type    cmd,
   input  ospfe_pkg::ctrl_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SELF,
      S_SCAN,
      S_RESOLVE,
      S_ROLE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      changed_ff, changed_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.changed  = changed_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == ospfe_pkg::OPC_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  second_in  = 1'b0;
                  changed_in = 1'b0;
                  state_in   = status.p2p ? S_RESP : S_SELF;
               end
            end
         end
         S_SELF: begin
            cmd.start = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            if (second_ff) begin
               state_in = S_ROLE;
            end else if (status.differ) begin
               changed_in = 1'b1;
               second_in  = 1'b1;
               state_in   = S_SELF;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ROLE: begin
            cmd.role = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ospfe_dp.sv
// Datapath of the OSPF DR/BDR election block: configuration registers,
// slot valid bits, neighbor table RAM, candidate accumulators and results.
// Depends on ospfe_pkg and ospfe_ram.
module ospfe_dp #(
   parameter int NEIGHBOR_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ospfe_pkg::CSR_A_W-1:0]        csr_index,
   input  logic [ospfe_pkg::ID_W-1:0]           csr_wdata,
   input  logic [ospfe_pkg::SLOT_W-1:0]         req_slot,
   input  logic                                 req_entry_valid,
   input  ospfe_pkg::nbr_type                   req_entry,
   input  ospfe_pkg::ctrl_cmd_type              cmd,
   output ospfe_pkg::ctrl_status_type           status,
   output logic [ospfe_pkg::ID_W-1:0]           rsp_dr_id,
   output logic [ospfe_pkg::ID_W-1:0]           rsp_bdr_id,
   output logic                                 rsp_changed,
   output logic [ospfe_pkg::ROLE_W-1:0]         rsp_role
);

   localparam int IDX_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBOR_SLOTS - 1);

   logic [ospfe_pkg::ID_W-1:0]   own_rid_ff;
   logic [ospfe_pkg::PRIO_W-1:0] own_prio_ff;
   logic [ospfe_pkg::ID_W-1:0]   own_addr_ff;
   logic [ospfe_pkg::VER_W-1:0]  version_ff;
   logic                         p2p_ff;

   logic [NEIGHBOR_SLOTS-1:0]    valid_ff;
   logic [IDX_W-1:0]             idx_ff, idx_in;

   logic [ospfe_pkg::ID_W-1:0]   cur_dr_ff, cur_bdr_ff;
   logic [ospfe_pkg::ROLE_W-1:0] role_ff, role_in;

   ospfe_pkg::cand_type          dr_c_ff, bdr_c_ff, alt_c_ff;
   ospfe_pkg::cand_type          dr_c_in, bdr_c_in, alt_c_in;
   ospfe_pkg::cand_type          dr_base, bdr_base, alt_base, best, new_c;
   ospfe_pkg::cand_type          bdr_sel, dr_sel;

   logic [ospfe_pkg::ID_W-1:0]   out_dr_ff, out_bdr_ff;
   logic                         out_changed_ff;
   logic [ospfe_pkg::ROLE_W-1:0] out_role_ff;

   ospfe_pkg::nbr_type           ram_rd_data;
   ospfe_pkg::nbr_type           ent;
   logic                         ent_valid;
   logic                         by_addr;
   logic                         eligible, is_dr, is_bdr, better;
   logic [ospfe_pkg::ID_W-1:0]   ent_id, own_id, new_dr, new_bdr;
   logic                         wr_ok;
   logic [IDX_W-1:0]             wr_addr;

   assign by_addr = (version_ff == ospfe_pkg::VERSION_BY_ADDRESS);
   assign own_id  = by_addr ? own_addr_ff : own_rid_ff;
   assign wr_ok   = cmd.write && (32'(req_slot) < NEIGHBOR_SLOTS);
   assign wr_addr = IDX_W'(req_slot);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   ospfe_ram #(
      .WIDTH (ospfe_pkg::NBR_W),
      .DEPTH (NEIGHBOR_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (req_entry),
      .rd_en   (1'b1),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   // evaluate the local router at pass start, then one table slot per cycle
   always_comb begin
      if (cmd.start) begin
         ent.two_way = 1'b1;
         ent.prio    = own_prio_ff;
         ent.rid     = own_rid_ff;
         ent.addr    = own_addr_ff;
         ent.dr      = cur_dr_ff;
         ent.bdr     = cur_bdr_ff;
         ent_valid   = 1'b1;
         dr_base     = '0;
         bdr_base    = '0;
         alt_base    = '0;
      end else begin
         ent         = ram_rd_data;
         ent_valid   = valid_ff[idx_ff];
         dr_base     = dr_c_ff;
         bdr_base    = bdr_c_ff;
         alt_base    = alt_c_ff;
      end
      eligible = ent_valid && ent.two_way && (ent.prio != '0);
      ent_id   = by_addr ? ent.addr : ent.rid;
      is_dr    = (ent.dr == ent_id);
      is_bdr   = !is_dr && (ent.bdr == ent_id);
      best     = is_dr ? dr_base : (is_bdr ? bdr_base : alt_base);
      better   = !best.found || ({ent.prio, ent.rid} > {best.prio, best.rid});
      new_c.found = 1'b1;
      new_c.prio  = ent.prio;
      new_c.rid   = ent.rid;
      new_c.ident = ent_id;
      dr_c_in  = dr_base;
      bdr_c_in = bdr_base;
      alt_c_in = alt_base;
      if (eligible && better) begin
         if (is_dr) begin
            dr_c_in = new_c;
         end else if (is_bdr) begin
            bdr_c_in = new_c;
         end else begin
            alt_c_in = new_c;
         end
      end
   end

   always_comb begin
      bdr_sel = bdr_c_ff.found ? bdr_c_ff : alt_c_ff;
      dr_sel  = dr_c_ff.found ? dr_c_ff : bdr_sel;
      new_dr  = dr_sel.found ? dr_sel.ident : '0;
      new_bdr = bdr_sel.found ? bdr_sel.ident : '0;
   end

   always_comb begin
      if (cur_dr_ff == own_id) begin
         role_in = ospfe_pkg::ROLE_DR;
      end else if ((cur_dr_ff != '0) && (cur_bdr_ff == own_id)) begin
         role_in = ospfe_pkg::ROLE_BACKUP;
      end else if (cur_dr_ff != '0) begin
         role_in = ospfe_pkg::ROLE_DR_OTHER;
      end else begin
         role_in = ospfe_pkg::ROLE_WAITING;
      end
   end

   assign status.last   = (idx_ff == LAST_IDX);
   assign status.differ = (new_dr != cur_dr_ff) || (new_bdr != cur_bdr_ff);
   assign status.p2p    = p2p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_rid_ff  <= '0;
         own_prio_ff <= ospfe_pkg::PRIO_W'(1);
         own_addr_ff <= '0;
         version_ff  <= ospfe_pkg::VERSION_BY_ADDRESS;
         p2p_ff      <= 1'b0;
         valid_ff    <= '0;
         cur_dr_ff   <= '0;
         cur_bdr_ff  <= '0;
         role_ff     <= ospfe_pkg::ROLE_WAITING;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ospfe_pkg::CSR_OWN_ROUTER_ID:    own_rid_ff  <= csr_wdata;
               ospfe_pkg::CSR_OWN_PRIORITY:     own_prio_ff <= csr_wdata[ospfe_pkg::PRIO_W-1:0];
               ospfe_pkg::CSR_OWN_ADDRESS:      own_addr_ff <= csr_wdata;
               ospfe_pkg::CSR_PROTOCOL_VERSION: version_ff  <= csr_wdata[ospfe_pkg::VER_W-1:0];
               ospfe_pkg::CSR_POINT_TO_POINT:   p2p_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
         if (wr_ok) begin
            valid_ff[wr_addr] <= req_entry_valid;
         end
         if (cmd.resolve) begin
            cur_dr_ff  <= new_dr;
            cur_bdr_ff <= new_bdr;
         end
         if (cmd.role) begin
            role_ff <= role_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.start || cmd.step) begin
         dr_c_ff  <= dr_c_in;
         bdr_c_ff <= bdr_c_in;
         alt_c_ff <= alt_c_in;
      end
      if (cmd.load) begin
         out_dr_ff      <= cur_dr_ff;
         out_bdr_ff     <= cur_bdr_ff;
         out_changed_ff <= cmd.changed;
         out_role_ff    <= role_ff;
      end
   end

   assign rsp_dr_id   = out_dr_ff;
   assign rsp_bdr_id  = out_bdr_ff;
   assign rsp_changed = out_changed_ff;
   assign rsp_role    = out_role_ff;

endmodule
